### rtl/mpq_pkg.sv
// mpq_pkg: types and constants shared by the max priority queue files.
// No dependencies; compiled first.
package mpq_pkg;

  localparam int VAL_W   = 32;
  localparam int ENT_W   = 7;
  localparam int CAP_W   = 7;
  localparam int STAT_W  = 2;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = 7'd64;

  // operation codes on the input word
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // register index of capacity_limit
  localparam logic REG_CAP = 1'b0;

  // operation broadcast to every cell
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [VAL_W-1:0] val;
  } mpq_op_t;

  // what one cell shows its neighbours
  typedef struct packed {
    logic                    vld;
    logic                    ge;
    logic signed [VAL_W-1:0] val;
  } mpq_link_t;

endpackage

### rtl/mpq_in_if.sv
// mpq_in_if: valid/ready channel that carries one queue operation word.
// Depends on mpq_pkg for field widths.
interface mpq_in_if import mpq_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

### rtl/mpq_out_if.sv
// mpq_out_if: valid/ready channel that carries one queue result word.
// Depends on mpq_pkg for field widths.
interface mpq_out_if import mpq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  top_value;
  logic                     is_empty;
  logic [ENT_W-1:0]         entry_total;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output top_value, output is_empty,
                  output entry_total, output status, input ready);
  modport sink   (input valid, input top_value, input is_empty,
                  input entry_total, input status, output ready);
endinterface

### rtl/max_priority_queue_unit.sv
// max_priority_queue_unit: systolic max priority queue of signed 32-bit words.
// Depends on mpq_pkg, mpq_in_if, mpq_out_if, mpq_cell and mpq_cfg.
//
// Usage: each word on in_ch is a push (cmd 0) of value or a pop (cmd 1) of
// the maximum. Every accepted word yields exactly one word on out_ch with
// the new maximum (0 when empty), the empty flag, the entry count and a
// status: done, push dropped because full, or pop on empty.
// The store is a row of DEPTH cells kept sorted, largest first; all cells
// see the operation and trade values with their neighbours in the same cycle.
// The cells update on the accepting edge and the result register then loads
// from them, so a new word is accepted only once the previous result has been
// loaded; in_ch.ready is low during the update cycle.
// A full result register that out_ch does not take holds in_ch.ready low
// until it is taken; nothing is dropped.
// Reset (rst_n low, synchronous) empties the queue and sets capacity_limit
// to 64; no clearing pass is needed. capacity_limit is written through the
// cfg_ port at byte address 0 and saturates at DEPTH.
module max_priority_queue_unit import mpq_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  mpq_in_if.sink            in_ch,
  mpq_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [CAP_W-1:0]        cap;
  logic [CMP_W-1:0]        cap_eff;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    pend_r, pend_nxt;
  logic [STAT_W-1:0]       stat_r, stat_nxt;
  logic                    ov_r, ov_nxt;
  logic signed [VAL_W-1:0] otop_r, otop_nxt;
  logic                    oemp_r, oemp_nxt;
  logic [ENT_W-1:0]        otot_r, otot_nxt;
  logic [STAT_W-1:0]       ost_r, ost_nxt;
  logic                    acc, full, empty;
  mpq_op_t                 op;
  mpq_link_t               link [DEPTH];
  mpq_link_t               top_up, tail_dn;

  mpq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cap_o   (cap)
  );

  // saturate the capacity at the number of cells
  assign cap_eff = (CMP_W'(cap) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap);
  assign full    = CMP_W'(cnt_r) >= cap_eff;
  assign empty   = (cnt_r == '0);

  assign in_ch.ready = !pend_r && (!ov_r || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;

  // broadcast the operation; a push is dropped when full, a pop when empty
  assign op.push = acc && (in_ch.cmd == CMD_PUSH) && !full;
  assign op.pop  = acc && (in_ch.cmd == CMD_POP) && !empty;
  assign op.val  = in_ch.value;

  // ends of the chain: the head takes the new value when it does not stay ahead, nothing below the tail
  assign top_up  = '{vld: 1'b0, ge: 1'b1, val: '0};
  assign tail_dn = '{vld: 1'b0, ge: 1'b0, val: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mpq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .op_i  (op),
      .up_i  ((i == 0) ? top_up : link[(i == 0) ? 0 : i - 1]),
      .dn_i  ((i == DEPTH - 1) ? tail_dn : link[(i == DEPTH - 1) ? i : i + 1]),
      .own_o (link[i])
    );
  end

  // count, status and pending result
  always_comb begin
    cnt_nxt  = cnt_r;
    stat_nxt = stat_r;
    pend_nxt = 1'b0;
    if (op.push) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (op.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    if (acc) begin
      pend_nxt = 1'b1;
      if (in_ch.cmd == CMD_PUSH) begin
        stat_nxt = full ? ST_FULL : ST_DONE;
      end else begin
        stat_nxt = empty ? ST_EMPTY : ST_DONE;
      end
    end
  end

  // load the result word once the cells have settled; hold until taken
  always_comb begin
    ov_nxt   = ov_r && !out_ch.ready;
    otop_nxt = otop_r;
    oemp_nxt = oemp_r;
    otot_nxt = otot_r;
    ost_nxt  = ost_r;
    if (pend_r) begin
      ov_nxt   = 1'b1;
      otop_nxt = link[0].vld ? link[0].val : '0;
      oemp_nxt = empty;
      otot_nxt = ENT_W'(cnt_r);
      ost_nxt  = stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stat_r <= stat_nxt;
    otop_r <= otop_nxt;
    oemp_r <= oemp_nxt;
    otot_r <= otot_nxt;
    ost_r  <= ost_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.top_value   = otop_r;
  assign out_ch.is_empty    = oemp_r;
  assign out_ch.entry_total = otot_r;
  assign out_ch.status      = ost_r;

  // head cell is occupied exactly when the count is non-zero
  a_head_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    link[0].vld == (cnt_r != '0))
    else $error("head cell occupancy disagrees with count");

  // tail cell is occupied only when every cell is
  a_tail_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    link[DEPTH-1].vld |-> (cnt_r == CNT_W'(DEPTH)))
    else $error("tail cell occupied below full count");

  // count never exceeds the saturated capacity after a push
  a_push_cap: assert property (@(posedge clk) disable iff (!rst_n)
    op.push |=> (CMP_W'(cnt_r) <= $past(cap_eff)))
    else $error("push took count above capacity");

  // the head never grows on a pop that leaves an entry behind
  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    (op.pop && link[1].vld) |=> (link[0].val <= $past(link[0].val)))
    else $error("pop raised the maximum");

endmodule

### rtl/mpq_cell.sv
// mpq_cell: one slot of the sorted systolic queue; holds one value.
// Depends on mpq_pkg for the operation and link structs.
module mpq_cell import mpq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mpq_op_t   op_i,
  input  mpq_link_t up_i,
  input  mpq_link_t dn_i,
  output mpq_link_t own_o
);

  logic                    vld_r, vld_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic                    ge;

  // this slot stays ahead of the incoming value
  assign ge = vld_r && (val_r >= op_i.val);

  // push: keep, take the new value, or shift down; pop: pull up from below
  always_comb begin
    vld_nxt = vld_r;
    val_nxt = val_r;
    if (op_i.push) begin
      if (!ge) begin
        if (up_i.ge) begin
          vld_nxt = 1'b1;
          val_nxt = op_i.val;
        end else begin
          vld_nxt = up_i.vld;
          val_nxt = up_i.val;
        end
      end
    end else if (op_i.pop) begin
      vld_nxt = dn_i.vld;
      val_nxt = dn_i.val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign own_o.vld = vld_r;
  assign own_o.ge  = ge;
  assign own_o.val = val_r;

endmodule

### rtl/mpq_cfg.sv
// mpq_cfg: APB-style register port holding capacity_limit.
// Depends on mpq_pkg for widths, reset value and register index.
module mpq_cfg import mpq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CAP_W-1:0]  cap_o
);

  logic [CAP_W-1:0] cap_r, cap_nxt;
  logic             hit;

  assign hit    = (paddr[APB_AW-1] == REG_CAP);
  assign pready = 1'b1;

  // write on the access phase
  always_comb begin
    cap_nxt = cap_r;
    if (psel && penable && pwrite && hit) begin
      cap_nxt = pwdata[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  assign prdata = hit ? APB_DW'(cap_r) : '0;
  assign cap_o  = cap_r;

endmodule
